// ===== hdl/adga_pkg.sv =====
package adga_pkg;

	localparam int SUBWINDOW_LEN_DEF = 48;
	localparam int SAMPLE_W = 28;
	localparam int THR_W = 28;
	localparam int COEFF_W = 32;
	localparam int CFG_W = 32;
	localparam int COUNT_W = 32;
	localparam int POWER_W = 63;
	localparam int STATE_WIDTH = 48;
	localparam int CHUNK = 24;
	localparam int HI_W = STATE_WIDTH - CHUNK;
	localparam int MUL_W = 33;
	localparam int PROD_W = 2 * MUL_W;
	localparam int ACC_W = 2 * STATE_WIDTH + 4;
	localparam int FRAC = 30;
	localparam int SQ_W = 2 * SAMPLE_W - 1;
	localparam int STEP_W = 5;
	localparam int IN_DATA_W = 32;
	localparam int OUT_DATA_W = 192;

	typedef enum logic [1:0] {
		CFG_CLICK_THR  = 2'd0,
		CFG_DROP_FLOOR = 2'd1,
		CFG_COEFF      = 2'd2
	} cfg_idx_t;

	// multiplier operand sources, H/L are the upper and lower chunks of a state word
	typedef enum logic [2:0] {
		SRC_X  = 3'd0,
		SRC_C  = 3'd1,
		SRC_FH = 3'd2,
		SRC_FL = 3'd3,
		SRC_SH = 3'd4,
		SRC_SL = 3'd5,
		SRC_MH = 3'd6,
		SRC_ML = 3'd7
	} src_t;

	typedef enum logic [1:0] {
		OP_NOP  = 2'd0,
		OP_LOAD = 2'd1,
		OP_ADD  = 2'd2,
		OP_SUB  = 2'd3
	} acc_op_t;

	typedef enum logic [1:0] {
		SH_0   = 2'd0,
		SH_ONE = 2'd1,
		SH_TWO = 2'd2
	} sh_t;

	typedef enum logic [1:0] {
		J_NEXT    = 2'd0,
		J_WAIT_IN = 2'd1,
		J_WEND    = 2'd2,
		J_GOTO    = 2'd3
	} jmp_t;

	typedef logic [STEP_W-1:0] step_t;

	localparam step_t U_IDLE    = 5'd0;
	localparam step_t U_SQ      = 5'd1;
	localparam step_t U_CFH     = 5'd2;
	localparam step_t U_CFL     = 5'd3;
	localparam step_t U_DRAIN   = 5'd4;
	localparam step_t U_UPD     = 5'd5;
	localparam step_t U_WFH     = 5'd6;
	localparam step_t U_WFL     = 5'd7;
	localparam step_t U_WDRAIN  = 5'd8;
	localparam step_t U_S1HH    = 5'd9;
	localparam step_t U_S1HL    = 5'd10;
	localparam step_t U_S1LH    = 5'd11;
	localparam step_t U_S1LL    = 5'd12;
	localparam step_t U_S2HH    = 5'd13;
	localparam step_t U_S2HL    = 5'd14;
	localparam step_t U_S2LH    = 5'd15;
	localparam step_t U_S2LL    = 5'd16;
	localparam step_t U_MHH     = 5'd17;
	localparam step_t U_MHL     = 5'd18;
	localparam step_t U_MLH     = 5'd19;
	localparam step_t U_MLL     = 5'd20;
	localparam step_t U_FDRAIN  = 5'd21;
	localparam step_t U_REPORT  = 5'd22;

	// one control word; the accumulate op applies in the cycle after, when the registered product lands
	typedef struct packed {
		src_t    a;
		src_t    b;
		acc_op_t op;
		sh_t     sh;
		logic    psum;
		logic    gupd;
		logic    msave;
		logic    out_sample;
		logic    out_window;
		jmp_t    jmp;
		step_t   target;
	} uword_t;

	function automatic uword_t mul_word(src_t a, src_t b, acc_op_t op, sh_t sh);
		uword_t w;
		w = '0;
		w.a = a;
		w.b = b;
		w.op = op;
		w.sh = sh;
		return w;
	endfunction

	function automatic uword_t ucode(step_t s);
		uword_t w;
		w = '0;
		case (s)
			U_IDLE: begin
				w.jmp = J_WAIT_IN;
			end
			U_SQ:     w = mul_word(SRC_X, SRC_X, OP_LOAD, SH_0);
			U_CFH:    w = mul_word(SRC_C, SRC_FH, OP_LOAD, SH_ONE);
			U_CFL: begin
				w = mul_word(SRC_C, SRC_FL, OP_ADD, SH_0);
				w.psum = 1'b1;
			end
			U_DRAIN:  w = '0;
			U_UPD: begin
				w.gupd = 1'b1;
				w.out_sample = 1'b1;
				w.jmp = J_WEND;
				w.target = U_IDLE;
			end
			U_WFH:    w = mul_word(SRC_C, SRC_FH, OP_LOAD, SH_ONE);
			U_WFL:    w = mul_word(SRC_C, SRC_FL, OP_ADD, SH_0);
			U_WDRAIN: w = '0;
			U_S1HH: begin
				w = mul_word(SRC_FH, SRC_FH, OP_LOAD, SH_TWO);
				w.msave = 1'b1;
			end
			U_S1HL:   w = mul_word(SRC_FH, SRC_FL, OP_ADD, SH_ONE);
			U_S1LH:   w = mul_word(SRC_FL, SRC_FH, OP_ADD, SH_ONE);
			U_S1LL:   w = mul_word(SRC_FL, SRC_FL, OP_ADD, SH_0);
			U_S2HH:   w = mul_word(SRC_SH, SRC_SH, OP_ADD, SH_TWO);
			U_S2HL:   w = mul_word(SRC_SH, SRC_SL, OP_ADD, SH_ONE);
			U_S2LH:   w = mul_word(SRC_SL, SRC_SH, OP_ADD, SH_ONE);
			U_S2LL:   w = mul_word(SRC_SL, SRC_SL, OP_ADD, SH_0);
			U_MHH:    w = mul_word(SRC_SH, SRC_MH, OP_SUB, SH_TWO);
			U_MHL:    w = mul_word(SRC_SH, SRC_ML, OP_SUB, SH_ONE);
			U_MLH:    w = mul_word(SRC_SL, SRC_MH, OP_SUB, SH_ONE);
			U_MLL:    w = mul_word(SRC_SL, SRC_ML, OP_SUB, SH_0);
			U_FDRAIN: w = '0;
			U_REPORT: begin
				w.out_window = 1'b1;
				w.jmp = J_GOTO;
				w.target = U_IDLE;
			end
			default: begin
				w.jmp = J_GOTO;
				w.target = U_IDLE;
			end
		endcase
		return w;
	endfunction

	// clamp a wide signed value into the signed state range
	function automatic logic signed [STATE_WIDTH-1:0] sat_state(logic signed [ACC_W-1:0] v);
		logic [ACC_W-STATE_WIDTH:0] upper;
		logic signed [STATE_WIDTH-1:0] r;
		upper = v[ACC_W-1:STATE_WIDTH-1];
		if ((&upper) || !(|upper))
			r = v[STATE_WIDTH-1:0];
		else if (v[ACC_W-1])
			r = {1'b1, {(STATE_WIDTH-1){1'b0}}};
		else
			r = {1'b0, {(STATE_WIDTH-1){1'b1}}};
		return r;
	endfunction

endpackage

// ===== hdl/adga_seq.sv =====
module adga_seq (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             in_fire,
	input  logic             window_end,
	input  logic             out_busy,
	output adga_pkg::uword_t ctl,
	output logic             adv
);
	import adga_pkg::*;

	step_t step_q;
	logic  emit;

	assign ctl = ucode(step_q);
	assign emit = ctl.out_window | (ctl.out_sample & ~window_end);

	// a step that loads the result register holds while the previous beat is unclaimed
	always_comb begin
		case (ctl.jmp)
			J_WAIT_IN: adv = in_fire;
			default:   adv = ~(emit & out_busy);
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			step_q <= U_IDLE;
		end else if (adv) begin
			case (ctl.jmp)
				J_WEND:  step_q <= window_end ? step_q + step_t'(1) : ctl.target;
				J_GOTO:  step_q <= ctl.target;
				default: step_q <= step_q + step_t'(1);
			endcase
		end
	end

endmodule

// ===== hdl/audio_defect_goertzel_analyzer.sv =====
// channel   | signals                          | beat contents
// ----------+----------------------------------+-----------------------------------------
// s_axis    | tvalid tready tdata tlast        | sample in tdata, window_end in tlast
// m_axis    | tvalid tready tdata tuser        | counts and powers in tdata, window_valid
// cfg       | cfg_we cfg_index cfg_data        | click_threshold, dropout_floor, coeff
//
// an ordinary sample has its result registered after the square, coefficient and state
// update steps; a window-closing sample goes on through the power steps to the report, all
// on the single 33x33 multiplier, which the microcode steps one partial product a cycle.
// reset clears all counters, the Goertzel state and the power sum; no clearing pass.
// the next sample is taken as soon as the sequencer is back at idle, even while the
// last result still waits; a held result stalls only the step that would overwrite it.
module audio_defect_goertzel_analyzer #(
	parameter int SUBWINDOW_LEN = adga_pkg::SUBWINDOW_LEN_DEF
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              s_axis_tvalid,
	output logic                              s_axis_tready,
	input  logic [adga_pkg::IN_DATA_W-1:0]    s_axis_tdata,  // sample[27:0], zero pad
	input  logic                              s_axis_tlast,  // window_end
	output logic                              m_axis_tvalid,
	input  logic                              m_axis_tready,
	output logic [adga_pkg::OUT_DATA_W-1:0]   m_axis_tdata,  // click_count[31:0],
	                                                         // dropout_count[63:32],
	                                                         // bin_power[126:64],
	                                                         // total_power[189:127], pad
	output logic                              m_axis_tuser,  // window_valid
	input  logic                              cfg_we,
	input  logic [1:0]                        cfg_index,
	input  logic [adga_pkg::CFG_W-1:0]        cfg_data
);
	import adga_pkg::*;

	localparam int POS_W = $clog2(SUBWINDOW_LEN);

	// configuration
	logic [THR_W-1:0]          thr_q;
	logic [THR_W-1:0]          floor_q;
	logic signed [COEFF_W-1:0] coeff_q;

	// per-sample state
	logic signed [SAMPLE_W-1:0] prev_q;
	logic [SAMPLE_W-1:0]        peak_q;
	logic [POS_W-1:0]           pos_q;
	logic [COUNT_W-1:0]         clicks_q;
	logic [COUNT_W-1:0]         drops_q;
	logic signed [STATE_WIDTH-1:0] first_q;
	logic signed [STATE_WIDTH-1:0] second_q;
	logic signed [STATE_WIDTH-1:0] m_q;
	logic [POWER_W-1:0]         psum_q;

	logic signed [SAMPLE_W-1:0] x_q;
	logic                       wend_q;

	// multiply-accumulate datapath
	logic signed [MUL_W-1:0]  mul_a;
	logic signed [MUL_W-1:0]  mul_b;
	logic signed [PROD_W-1:0] prod_q;
	acc_op_t                  op_q;
	sh_t                      sh_q;
	logic signed [ACC_W-1:0]  prod_ext;
	logic signed [ACC_W-1:0]  term;
	logic signed [ACC_W-1:0]  acc_q;

	// result register
	logic               out_valid_q;
	logic [COUNT_W-1:0] out_click_q;
	logic [COUNT_W-1:0] out_drop_q;
	logic               out_wv_q;
	logic [POWER_W-1:0] out_bin_q;
	logic [POWER_W-1:0] out_total_q;

	uword_t ctl;
	logic   adv;
	logic   in_fire;
	logic   out_busy;
	logic   sample_out;
	logic   window_out;

	logic signed [SAMPLE_W-1:0] x_in;
	logic signed [SAMPLE_W:0]   diff;
	logic signed [SAMPLE_W:0]   diff_abs;
	logic [SAMPLE_W-1:0]        ax;
	logic [SAMPLE_W-1:0]        peak_n;
	logic                       sub_end;

	logic signed [STATE_WIDTH-1:0] m_cur;
	logic signed [ACC_W-1:0]       s_sum;
	logic [POWER_W:0]              psum_add;
	logic [POWER_W-1:0]            bin_clamp;

	assign in_fire  = s_axis_tvalid & s_axis_tready;
	assign out_busy = out_valid_q & ~m_axis_tready;

	adga_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_fire    (in_fire),
		.window_end (wend_q),
		.out_busy   (out_busy),
		.ctl        (ctl),
		.adv        (adv)
	);

	assign s_axis_tready = (ctl.jmp == J_WAIT_IN);
	assign sample_out = adv & ctl.out_sample & ~wend_q;
	assign window_out = adv & ctl.out_window;

	// config writes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			thr_q   <= '0;
			floor_q <= '0;
			coeff_q <= '0;
		end else if (cfg_we) begin
			case (cfg_index)
				CFG_CLICK_THR:  thr_q   <= cfg_data[THR_W-1:0];
				CFG_DROP_FLOOR: floor_q <= cfg_data[THR_W-1:0];
				CFG_COEFF:      coeff_q <= cfg_data[COEFF_W-1:0];
				default:        ;
			endcase
		end
	end

	// click and dropout checks run in the accept cycle
	assign x_in     = s_axis_tdata[SAMPLE_W-1:0];
	assign diff     = {x_in[SAMPLE_W-1], x_in} - {prev_q[SAMPLE_W-1], prev_q};
	assign diff_abs = diff[SAMPLE_W] ? -diff : diff;
	assign ax       = x_in[SAMPLE_W-1] ? SAMPLE_W'(-x_in) : SAMPLE_W'(x_in);
	assign peak_n   = (ax > peak_q) ? ax : peak_q;
	assign sub_end  = (pos_q == POS_W'(SUBWINDOW_LEN - 1));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_q   <= '0;
			peak_q   <= '0;
			pos_q    <= '0;
			clicks_q <= '0;
			drops_q  <= '0;
			wend_q   <= 1'b0;
		end else if (in_fire) begin
			wend_q <= s_axis_tlast;
			prev_q <= x_in;
			if ((thr_q != '0) && (diff_abs[SAMPLE_W-1:0] > thr_q))
				clicks_q <= clicks_q + COUNT_W'(1);
			if (sub_end) begin
				pos_q  <= '0;
				peak_q <= '0;
				if ((floor_q != '0) && (peak_n < floor_q))
					drops_q <= drops_q + COUNT_W'(1);
			end else begin
				pos_q  <= pos_q + POS_W'(1);
				peak_q <= peak_n;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire)
			x_q <= x_in;
	end

	// operand select
	function automatic logic signed [MUL_W-1:0] pick(
		src_t s,
		logic signed [SAMPLE_W-1:0] x,
		logic signed [COEFF_W-1:0] c,
		logic signed [STATE_WIDTH-1:0] f,
		logic signed [STATE_WIDTH-1:0] sc,
		logic signed [STATE_WIDTH-1:0] m
	);
		logic signed [MUL_W-1:0] r;
		case (s)
			SRC_X:   r = {{(MUL_W-SAMPLE_W){x[SAMPLE_W-1]}}, x};
			SRC_C:   r = {{(MUL_W-COEFF_W){c[COEFF_W-1]}}, c};
			SRC_FH:  r = {{(MUL_W-HI_W){f[STATE_WIDTH-1]}}, f[STATE_WIDTH-1:CHUNK]};
			SRC_FL:  r = {{(MUL_W-CHUNK){1'b0}}, f[CHUNK-1:0]};
			SRC_SH:  r = {{(MUL_W-HI_W){sc[STATE_WIDTH-1]}}, sc[STATE_WIDTH-1:CHUNK]};
			SRC_SL:  r = {{(MUL_W-CHUNK){1'b0}}, sc[CHUNK-1:0]};
			SRC_MH:  r = {{(MUL_W-HI_W){m[STATE_WIDTH-1]}}, m[STATE_WIDTH-1:CHUNK]};
			SRC_ML:  r = {{(MUL_W-CHUNK){1'b0}}, m[CHUNK-1:0]};
			default: r = '0;
		endcase
		return r;
	endfunction

	assign mul_a = pick(ctl.a, x_q, coeff_q, first_q, second_q, m_q);
	assign mul_b = pick(ctl.b, x_q, coeff_q, first_q, second_q, m_q);

	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_NOP;
			sh_q <= SH_0;
		end else begin
			op_q <= adv ? ctl.op : OP_NOP;
			sh_q <= ctl.sh;
		end
	end

	assign prod_ext = ACC_W'(prod_q);

	always_comb begin
		case (sh_q)
			SH_ONE:  term = prod_ext <<< CHUNK;
			SH_TWO:  term = prod_ext <<< (2 * CHUNK);
			default: term = prod_ext;
		endcase
	end

	always_ff @(posedge clk) begin
		case (op_q)
			OP_LOAD: acc_q <= term;
			OP_ADD:  acc_q <= acc_q + term;
			OP_SUB:  acc_q <= acc_q - term;
			default: acc_q <= acc_q;
		endcase
	end

	// coeff * s1 scaled back by 2^30
	assign m_cur = sat_state(acc_q >>> FRAC);
	assign s_sum = ACC_W'(x_q) + ACC_W'(m_cur) - ACC_W'(second_q);
	assign psum_add = {1'b0, psum_q} + (POWER_W + 1)'(acc_q[SQ_W-1:0]);

	always_comb begin
		if (acc_q[ACC_W-1])
			bin_clamp = '0;
		else if (|acc_q[ACC_W-2:POWER_W])
			bin_clamp = '1;
		else
			bin_clamp = acc_q[POWER_W-1:0];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			first_q  <= '0;
			second_q <= '0;
			psum_q   <= '0;
		end else begin
			if (adv && ctl.psum)
				psum_q <= psum_add[POWER_W] ? '1 : psum_add[POWER_W-1:0];
			if (adv && ctl.gupd) begin
				second_q <= first_q;
				first_q  <= sat_state(s_sum);
			end
			if (window_out) begin
				first_q  <= '0;
				second_q <= '0;
				psum_q   <= '0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (adv && ctl.msave)
			m_q <= m_cur;
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (sample_out || window_out) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (sample_out) begin
			out_click_q <= clicks_q;
			out_drop_q  <= drops_q;
			out_wv_q    <= 1'b0;
			out_bin_q   <= '0;
			out_total_q <= '0;
		end else if (window_out) begin
			out_click_q <= clicks_q;
			out_drop_q  <= drops_q;
			out_wv_q    <= 1'b1;
			out_bin_q   <= bin_clamp;
			out_total_q <= psum_q;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tuser  = out_wv_q;
	assign m_axis_tdata  = {{(OUT_DATA_W - 2 * COUNT_W - 2 * POWER_W){1'b0}},
		out_total_q, out_bin_q, out_drop_q, out_click_q};

endmodule
